@@ rtl/oil_pressure_sensor_conditioner_unit_macros.svh @@
// Assertion macros for the oil pressure sensor conditioner.
// Expects clock aclk and active-low reset aresetn in the module that uses them.
`ifndef OIL_PRESSURE_SENSOR_CONDITIONER_UNIT_MACROS_SVH
`define OIL_PRESSURE_SENSOR_CONDITIONER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define OPSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked out of reset
`define OPSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

@@ rtl/opsc_pkg.sv @@
// Shared types and constants for the oil pressure sensor conditioner.
// No dependencies; imported by every module of the block.
package opsc_pkg;

    localparam int SAMPLE_W = 12;   // converter sample
    localparam int SUM_W    = 20;   // block sum
    localparam int VAL_W    = 16;   // registers, average, pressures
    localparam int X_W      = 24;   // block sum with 4 fraction bits
    localparam int NUM_W    = 20;   // smoothing numerator
    localparam int CNT_N_W  = 9;    // holds the block length itself
    localparam int IDX_W    = 2;    // configuration register index

    // Reset values of the configuration registers
    localparam logic [VAL_W-1:0] ZERO_CODE_RST = 16'd4965;
    localparam logic [VAL_W-1:0] GAIN_RST      = 16'd2641;
    localparam logic [VAL_W-1:0] PMAX_RST      = 16'd25600;

    // Exact divide by ten for numerators below 2^22: (n * DIV10_MUL) >> DIV10_SHIFT
    localparam logic [NUM_W-1:0] DIV10_MUL   = 20'd838861;
    localparam int               DIV10_SHIFT = 23;

    // Pressure scale: (diff * gain) >> GAIN_SHIFT
    localparam int GAIN_SHIFT = 12;

    localparam int FIFO_DEPTH = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_ZERO_CODE = 2'd0,
        REG_GAIN      = 2'd1,
        REG_PMAX      = 2'd2
    } opsc_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_FIX,
        ST_AVG,
        ST_DIFF,
        ST_GAIN,
        ST_CLAMP,
        ST_MIX,
        ST_DIV,
        ST_PUT
    } opsc_state_t;

    // One finished block sum moving between front, queue and back
    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
    } opsc_blk_t;

    // Configuration seen by the back end
    typedef struct packed {
        logic [VAL_W-1:0] zero_code;
        logic [VAL_W-1:0] gain;
        logic [VAL_W-1:0] pressure_max;
    } opsc_cfg_t;

endpackage

@@ rtl/oil_pressure_sensor_conditioner_unit.sv @@
// Result path: a closed block is queued; the back-end sequencer then steps through
// scale, fix, average, diff, gain, clamp, mix, divide and put. One sample per cycle
// unless a closing sample finds the queue full; the back end pops only while idle.
// A two-entry block queue lets samples keep flowing while a result waits.
// Reset (aresetn low, synchronous) clears sums, counts, smoothed value, queue,
// and loads the configuration registers with their defaults.
module oil_pressure_sensor_conditioner_unit #(
    parameter int SAMPLES_PER_BLOCK = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,     // [11:0] sample, [15:12] zero
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,     // [15:0] block_pressure, [31:16] smoothed_pressure
    input  logic                       cfg_wr_en,
    input  logic [opsc_pkg::IDX_W-1:0] cfg_index,
    input  logic [opsc_pkg::VAL_W-1:0] cfg_wdata
);
    import opsc_pkg::*;

    opsc_cfg_t cfg_reg, cfg_next;
    opsc_blk_t push, head;
    logic      fifo_full;
    logic      pop;

    // Decode configuration writes; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_ZERO_CODE: cfg_next.zero_code    = cfg_wdata;
                REG_GAIN:      cfg_next.gain         = cfg_wdata;
                REG_PMAX:      cfg_next.pressure_max = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_code    <= ZERO_CODE_RST;
            cfg_reg.gain         <= GAIN_RST;
            cfg_reg.pressure_max <= PMAX_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    opsc_front #(
        .SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .fifo_full (fifo_full),
        .push      (push)
    );

    opsc_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (fifo_full),
        .pop     (pop),
        .head    (head)
    );

    opsc_back #(
        .SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .cfg      (cfg_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ rtl/opsc_front.sv @@
// Front end: accepts samples, accumulates block sums, pushes finished blocks.
// Depends on opsc_pkg.
module opsc_front #(
    parameter int SAMPLES_PER_BLOCK = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [11:0] sample, [15:12] zero
    input  logic                 fifo_full,
    output opsc_pkg::opsc_blk_t  push
);
    import opsc_pkg::*;

    localparam int CNT_W = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_BLOCK - 1);

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last;
    logic             accept;
    logic [SUM_W-1:0] sum_add;

    assign last     = (cnt_reg == LAST_CNT);
    // Stall only when this transaction would close a block and the queue is full
    assign s_tready = !fifo_full || !last;
    assign accept   = s_tvalid && s_tready;
    assign sum_add  = sum_reg + SUM_W'(s_tdata[SAMPLE_W-1:0]);

    assign push.valid = accept && last;
    assign push.sum   = sum_add;

    // Advance count and sum, restart on the last sample of a block
    always_comb begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (accept) begin
            if (last) begin
                sum_next = '0;
                cnt_next = '0;
            end else begin
                sum_next = sum_add;
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end else begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ rtl/opsc_fifo.sv @@
// Short queue of block sums between front and back end.
// Depends on opsc_pkg.
module opsc_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  opsc_pkg::opsc_blk_t  push,
    output logic                 full,
    input  logic                 pop,
    output opsc_pkg::opsc_blk_t  head
);
    import opsc_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int LVL_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(FIFO_DEPTH);

    logic [SUM_W-1:0] mem [FIFO_DEPTH];
    logic [SUM_W-1:0] head_sum_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic             do_push, do_pop;

    assign full       = (lvl_reg == LVL_FULL);
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && (lvl_reg != '0);
    assign head.valid = (lvl_reg != '0);
    assign head.sum   = head_sum_reg;

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = do_push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        lvl_next    = lvl_reg;
        if (do_push && !do_pop) begin
            lvl_next = lvl_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            lvl_next = lvl_reg - 1'b1;
        end
    end

    // Write the incoming sum; prefetch the next head, taking a same-edge write directly
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push.sum;
        end
        if (do_push && (wr_ptr_reg == rd_ptr_next)) begin
            head_sum_reg <= push.sum;
        end else begin
            head_sum_reg <= mem[rd_ptr_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            lvl_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            lvl_reg    <= lvl_next;
        end
    end

endmodule

@@ rtl/opsc_back.sv @@
// Back end: sequencer that turns a block sum into clamped and smoothed pressure.
// Depends on opsc_pkg and the assertion macro header.
`include "oil_pressure_sensor_conditioner_unit_macros.svh"

module opsc_back #(
    parameter int SAMPLES_PER_BLOCK = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  opsc_pkg::opsc_blk_t  head,
    output logic                 pop,
    input  opsc_pkg::opsc_cfg_t  cfg,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata    // [15:0] block_pressure, [31:16] smoothed_pressure
);
    import opsc_pkg::*;

    localparam int RCP_W = X_W + 1;
    // floor(2^24 / N): quotient estimate is low by at most one
    localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << X_W) / SAMPLES_PER_BLOCK);
    localparam logic [CNT_N_W-1:0] BLK_N = CNT_N_W'(SAMPLES_PER_BLOCK);
    localparam int QN_W = VAL_W + CNT_N_W;
    localparam int GP_W = 2 * VAL_W;
    localparam int PW_W = GP_W - GAIN_SHIFT;
    localparam int SP_W = X_W + RCP_W;
    localparam int DP_W = 2 * NUM_W;

    opsc_state_t state_reg, state_next;

    logic [X_W-1:0]       x_reg;
    logic [VAL_W-1:0]     q0_reg;
    logic [QN_W-1:0]      qn_reg;
    logic [VAL_W-1:0]     avg_reg;
    logic [VAL_W-1:0]     diff_reg;
    logic [GP_W-1:0]      gp_reg;
    logic [VAL_W-1:0]     p_reg;
    logic [NUM_W-1:0]     n_reg;
    logic [VAL_W-1:0]     smooth_reg;
    logic                 out_valid_reg;
    logic [2*VAL_W-1:0]   out_reg;

    logic [SP_W-1:0]      scale_prod;
    logic [X_W:0]         rem;
    logic [PW_W-1:0]      p_full;
    logic [DP_W-1:0]      div_prod;
    logic                 out_load;

    assign scale_prod = SP_W'(x_reg) * SP_W'(RECIP);
    assign rem        = {1'b0, x_reg} - (X_W+1)'(qn_reg);
    assign p_full     = gp_reg[GP_W-1:GAIN_SHIFT];
    assign div_prod   = DP_W'(n_reg) * DP_W'(DIV10_MUL);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // Next state and handshake controls
    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    pop        = 1'b1;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: state_next = ST_FIX;
            ST_FIX:   state_next = ST_AVG;
            ST_AVG:   state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_GAIN;
            ST_GAIN:  state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_MIX;
            ST_MIX:   state_next = ST_DIV;
            ST_DIV:   state_next = ST_PUT;
            ST_PUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath steps, one per sequencer state from idle through mix
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE:  x_reg  <= {head.sum, 4'b0000};
            ST_SCALE: q0_reg <= scale_prod[X_W +: VAL_W];
            ST_FIX:   qn_reg <= QN_W'(q0_reg) * QN_W'(BLK_N);
            ST_AVG: begin
                if (rem >= (X_W+1)'(BLK_N)) begin
                    avg_reg <= q0_reg + 1'b1;
                end else begin
                    avg_reg <= q0_reg;
                end
            end
            ST_DIFF: begin
                if (avg_reg > cfg.zero_code) begin
                    diff_reg <= avg_reg - cfg.zero_code;
                end else begin
                    diff_reg <= '0;
                end
            end
            ST_GAIN:  gp_reg <= GP_W'(diff_reg) * GP_W'(cfg.gain);
            ST_CLAMP: begin
                if (p_full > PW_W'(cfg.pressure_max)) begin
                    p_reg <= cfg.pressure_max;
                end else begin
                    p_reg <= p_full[VAL_W-1:0];
                end
            end
            ST_MIX: begin
                n_reg <= (NUM_W'(smooth_reg) << 3) - NUM_W'(smooth_reg)
                       + (NUM_W'(p_reg) << 1) + NUM_W'(p_reg);
            end
            default: begin
            end
        endcase
    end

    // Smoothed state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_DIV) begin
                smooth_reg <= div_prod[DIV10_SHIFT +: VAL_W];
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= {smooth_reg, p_reg};
        end
    end

    `OPSC_ASSERT_NEXT(a_put_loads_output, out_load,
                      out_valid_reg && out_reg[VAL_W-1:0] == $past(p_reg))
    `OPSC_ASSERT_NEXT(a_clamp_bound, state_reg == ST_CLAMP, p_reg <= cfg.pressure_max)
    `OPSC_ASSERT_NOW(a_pop_only_idle, pop, state_reg == ST_IDLE && head.valid)
    `OPSC_ASSERT_NEXT(a_put_waits, state_reg == ST_PUT && out_valid_reg && !m_tready,
                      state_reg == ST_PUT)

endmodule
